/* hdl/rdsgd_pkg.sv */
// rdsgd_pkg: shared types, codes and constants of the RDS group decoder.
// No dependencies; used by rdsgd_time_unit and rds_group_decoder_core.
package rdsgd_pkg;

  localparam int TEXT_CHARS  = 64;
  localparam int NAME_CHARS  = 8;
  localparam int TEXT_ROWS   = TEXT_CHARS / 4;   // four characters per type 2 group
  localparam int NAME_ROWS   = NAME_CHARS / 2;   // two characters per type 0 group
  localparam int MJD_2010    = 55198;
  localparam int DAY_MINUTES = 1440;
  localparam int HOUR_MINUTES = 60;
  localparam int HALF_HOUR   = 30;
  localparam int YEAR_DAYS   = 365;
  localparam int MONTHS      = 12;
  localparam int START_YEAR  = 10;
  localparam int ACC_W       = 18;               // signed day / minute accumulator

  localparam logic [1:0] ERR_UNCORR = 2'd3;

  localparam logic [3:0] GT_BASIC = 4'd0;
  localparam logic [3:0] GT_TEXT  = 4'd2;
  localparam logic [3:0] GT_CLOCK = 4'd4;

  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_READ   = 2'd1,
    OP_RETUNE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_TIME,
    ST_DONE
  } core_st_t;

  typedef enum logic [2:0] {
    TU_IDLE,
    TU_WALK,
    TU_OFFS,
    TU_FIX,
    TU_DIV
  } tu_st_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] day;
    logic [3:0] month;
    logic [7:0] year;
  } clock_time_t;

  function automatic logic [4:0] month_length(input logic [3:0] m);
    logic [4:0] n;
    unique case (m)
      4'd2:                      n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

/* hdl/rdsgd_time_unit.sv */
// rdsgd_time_unit: iterative MJD / UTC to local date and time converter.
// Depends on rdsgd_pkg. One shared adder runs walk, day fix, hour steps.
module rdsgd_time_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [15:0]            blk_b,
  input  logic [15:0]            blk_c,
  input  logic [15:0]            blk_d,
  output logic                   done,
  output rdsgd_pkg::clock_time_t ct
);
  import rdsgd_pkg::*;

  tu_st_t           st_r, st_nxt;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] addend;
  logic [ACC_W-1:0] sum;
  logic [4:0]       hour_r, hr_in_r;
  logic [5:0]       minute_r, mn_in_r;
  logic [5:0]       day_r;
  logic [3:0]       month_r;
  logic [7:0]       year_r;
  logic [4:0]       off_r;
  logic             off_neg_r;
  logic             done_r;
  logic [16:0]      mjd;
  logic             walk_on, yskip, fix_hi, fix_lo, div_on;
  logic [3:0]       month_step;
  logic [10:0]      hr_min;
  logic [9:0]       off_min;
  logic [ACC_W-1:0] t_sum;

  assign mjd        = {blk_b[1:0], blk_c[15:1]};
  assign walk_on    = $signed(acc_r) > 0;
  assign yskip      = (month_r == 4'd0 || month_r == 4'(MONTHS)) &&
                      ($signed(acc_r) > $signed(ACC_W'(YEAR_DAYS)));
  assign month_step = (month_r == 4'(MONTHS)) ? 4'd1 : month_r + 4'd1;
  assign fix_hi     = $signed(acc_r) >= $signed(ACC_W'(DAY_MINUTES));
  assign fix_lo     = acc_r[ACC_W-1];
  assign div_on     = acc_r >= ACC_W'(HOUR_MINUTES);

  // local minutes = minute + 60 * hour +/- 30 * offset
  assign hr_min  = 11'(hr_in_r) * 11'(HOUR_MINUTES);
  assign off_min = 10'(off_r) * 10'(HALF_HOUR);
  assign t_sum   = off_neg_r ? ACC_W'(mn_in_r) + ACC_W'(hr_min) - ACC_W'(off_min)
                             : ACC_W'(mn_in_r) + ACC_W'(hr_min) + ACC_W'(off_min);

  // shared adder
  always_comb begin
    addend = '0;
    unique case (st_r)
      TU_WALK: addend = yskip ? -ACC_W'(YEAR_DAYS) : -ACC_W'(month_length(month_step));
      TU_FIX:  addend = fix_lo ? ACC_W'(DAY_MINUTES) : -ACC_W'(DAY_MINUTES);
      TU_DIV:  addend = -ACC_W'(HOUR_MINUTES);
      default: addend = '0;
    endcase
  end
  assign sum = acc_r + addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TU_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      TU_IDLE: if (start) st_nxt = TU_WALK;
      TU_WALK: if (!walk_on) st_nxt = TU_OFFS;
      TU_OFFS: st_nxt = TU_FIX;
      TU_FIX:  st_nxt = TU_DIV;
      TU_DIV:  if (!div_on) st_nxt = TU_IDLE;
      default: st_nxt = TU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r   <= '0;
      minute_r <= '0;
      day_r    <= '0;
      month_r  <= '0;
      year_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        TU_IDLE: if (start) begin
          day_r   <= 6'd1;
          month_r <= 4'd0;
          year_r  <= 8'(START_YEAR);
        end
        TU_WALK: if (walk_on) begin
          if (yskip) begin
            year_r <= year_r + 8'd1;
          end else begin
            day_r   <= acc_r[5:0];
            month_r <= month_step;
            if (month_r == 4'(MONTHS)) year_r <= year_r + 8'd1;
          end
        end
        TU_FIX: begin
          hour_r <= '0;
          if (fix_hi) day_r <= day_r + 6'd1;
          else if (fix_lo) day_r <= day_r - 6'd1;
        end
        TU_DIV: begin
          if (div_on) begin
            hour_r <= hour_r + 5'd1;
          end else begin
            minute_r <= acc_r[5:0];
            done_r   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // accumulator and captured time fields: payload, no reset
  always_ff @(posedge clk) begin
    unique case (st_r)
      TU_IDLE: if (start) begin
        acc_r     <= ACC_W'(mjd) - ACC_W'(MJD_2010 - 1);
        hr_in_r   <= {blk_c[0], blk_d[15:12]};
        mn_in_r   <= blk_d[11:6];
        off_neg_r <= blk_d[5];
        off_r     <= blk_d[4:0];
      end
      TU_WALK: if (walk_on) acc_r <= sum;
      TU_OFFS: acc_r <= t_sum;
      TU_FIX:  if (fix_hi || fix_lo) acc_r <= sum;
      TU_DIV:  if (div_on) acc_r <= sum;
      default: ;
    endcase
  end

  assign done      = done_r;
  assign ct.hour   = hour_r;
  assign ct.minute = minute_r;
  assign ct.day    = day_r;
  assign ct.month  = month_r;
  assign ct.year   = year_r;

endmodule

/* hdl/rds_group_decoder_core.sv */
// rds_group_decoder_core: top level of the RDS group decoder.
// Depends on rdsgd_pkg and rdsgd_time_unit.
//
// Usage:
//   Input channel (in_*): one beat carries an operation and a whole RDS group
//   (blocks A-D with their error levels) or a read index. Output channel
//   (out_*): exactly one result beat per input beat, in order.
//   Decode latches PI/PTY/TP; an error-free group of type 0, 2 or 4 updates
//   the station name, radiotext or clock time. Read returns one stored
//   character, retune clears segment counters and the name/text valid flags.
// Flow (one item at a time, in_stall high while busy):
//   decode of type 0/2/other and retune: ST_EXEC, then ST_DONE, which loads
//   the output register once it is free and takes the next beat in ST_IDLE,
//   read: ST_READ follows ST_EXEC for the registered radiotext memory read,
//   clock time group: ST_TIME follows ST_EXEC and waits for the time unit to
//   finish the month walk (one year or one month per cycle) and one step
//   per hour of the local time.
// The output register frees the front: a new beat is taken while the last
//   result still waits under out_stall; the next result waits in ST_DONE.
// Reset (synchronous, rst_n low): stores, counters, flags and clock time go
//   to zero. Radiotext rows carry valid bits, so no clearing pass is needed.
module rds_group_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_block_a,
  input  logic [15:0] in_block_b,
  input  logic [15:0] in_block_c,
  input  logic [15:0] in_block_d,
  input  logic [1:0]  in_error_a,
  input  logic [1:0]  in_error_b,
  input  logic [1:0]  in_error_c,
  input  logic [1:0]  in_error_d,
  input  logic [6:0]  in_read_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_program_id,
  output logic [4:0]  out_program_type,
  output logic [4:0]  out_flags,
  output logic [3:0]  out_decoder_id,
  output logic [7:0]  out_read_char,
  output logic        out_time_valid,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_day,
  output logic [3:0]  out_month,
  output logic [7:0]  out_year
);
  import rdsgd_pkg::*;

  core_st_t    state_r, state_nxt;

  // captured beat
  op_t         op_r;
  logic [15:0] a_r, b_r, c_r, d_r;
  logic        clean_r;
  logic [6:0]  idx_r;

  // station info and reception counters
  logic [15:0] pi_r;
  logic [4:0]  pty_r;
  logic        tp_r, ta_r, ms_r;
  logic [3:0]  di_r;
  logic [3:0]  text_seen_r;
  logic [1:0]  name_seen_r;
  logic        name_ok_r, text_ok_r;

  // radiotext memory: one 32-bit row per type 2 segment, row valid bits
  logic [31:0]          text_mem [TEXT_ROWS];
  logic [TEXT_ROWS-1:0] text_vld_r;
  logic [31:0]          text_rd_r;
  logic                 text_rd_vld_r;

  // station name: four 16-bit rows in flops
  logic [15:0] name_r [NAME_ROWS];

  logic [7:0]  rd_r, rd_nxt;
  logic        tv_r;

  logic        in_acc, out_load;
  logic        do_decode, txt_we, name_we, tu_start, do_retune;
  logic [3:0]  gtype;
  logic [3:0]  text_seen_inc;
  logic [1:0]  name_seen_inc;

  logic        tu_done;
  clock_time_t ct;

  logic        out_valid_r;
  logic [15:0] out_pi_r;
  logic [4:0]  out_pty_r, out_flags_r, out_hour_r;
  logic [3:0]  out_di_r, out_month_r;
  logic [7:0]  out_rd_r, out_year_r;
  logic        out_tv_r;
  logic [5:0]  out_minute_r, out_day_r;

  rdsgd_time_unit u_time (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tu_start),
    .blk_b (b_r),
    .blk_c (c_r),
    .blk_d (d_r),
    .done  (tu_done),
    .ct    (ct)
  );

  assign gtype         = b_r[15:12];
  assign text_seen_inc = text_seen_r + 4'd1;
  assign name_seen_inc = name_seen_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != ST_IDLE);
    in_acc    = in_valid && !in_stall;
    do_decode = 1'b0;
    txt_we    = 1'b0;
    name_we   = 1'b0;
    tu_start  = 1'b0;
    do_retune = 1'b0;
    out_load  = 1'b0;
    rd_nxt    = 8'd0;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (op_r)
          OP_DECODE: begin
            do_decode = 1'b1;
            txt_we    = clean_r && (gtype == GT_TEXT);
            name_we   = clean_r && (gtype == GT_BASIC);
            tu_start  = clean_r && (gtype == GT_CLOCK);
            if (tu_start) state_nxt = ST_TIME;
          end
          OP_READ:   state_nxt = ST_READ;
          OP_RETUNE: do_retune = 1'b1;
          default:   ;
        endcase
      end
      ST_READ: begin
        state_nxt = ST_DONE;
        // index 0..63 radiotext, 64..71 station name, above that zero
        if (!idx_r[6]) begin
          if (text_rd_vld_r) rd_nxt = text_rd_r[5'(31 - 8 * idx_r[1:0]) -: 8];
        end else if (idx_r[5:3] == 3'd0) begin
          rd_nxt = idx_r[0] ? name_r[idx_r[2:1]][7:0] : name_r[idx_r[2:1]][15:8];
        end
      end
      ST_TIME: if (tu_done) state_nxt = ST_DONE;
      ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= op_t'(in_operation);
      a_r     <= in_block_a;
      b_r     <= in_block_b;
      c_r     <= in_block_c;
      d_r     <= in_block_d;
      clean_r <= (in_error_a != ERR_UNCORR) && (in_error_b != ERR_UNCORR) &&
                 (in_error_c != ERR_UNCORR) && (in_error_d != ERR_UNCORR);
      idx_r   <= in_read_index;
    end
  end

  // station info, counters, name store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pi_r        <= '0;
      pty_r       <= '0;
      tp_r        <= 1'b0;
      ta_r        <= 1'b0;
      ms_r        <= 1'b0;
      di_r        <= '0;
      text_seen_r <= '0;
      name_seen_r <= '0;
      name_ok_r   <= 1'b0;
      text_ok_r   <= 1'b0;
      text_vld_r  <= '0;
      for (int i = 0; i < NAME_ROWS; i++) name_r[i] <= '0;
    end else begin
      if (do_decode) begin
        pi_r  <= a_r;
        pty_r <= b_r[9:5];
        tp_r  <= b_r[10];
      end
      if (txt_we) begin
        text_seen_r          <= text_seen_inc;
        text_vld_r[b_r[3:0]] <= 1'b1;
        if (text_seen_inc == 4'd0) text_ok_r <= 1'b1;
      end
      if (name_we) begin
        di_r[b_r[1:0]]   <= b_r[2];
        ms_r             <= b_r[3];
        ta_r             <= b_r[4];
        name_r[b_r[1:0]] <= d_r;
        name_seen_r      <= name_seen_inc;
        if (name_seen_inc == 2'd0) name_ok_r <= 1'b1;
      end
      if (do_retune) begin
        text_seen_r <= '0;
        name_seen_r <= '0;
        name_ok_r   <= 1'b0;
        text_ok_r   <= 1'b0;
      end
    end
  end

  // radiotext memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (txt_we) text_mem[b_r[3:0]] <= {c_r, d_r};
    text_rd_r     <= text_mem[idx_r[5:2]];
    text_rd_vld_r <= text_vld_r[idx_r[5:2]];
  end

  // per-item read char and time flag
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= 8'd0;
      tv_r <= 1'b0;
    end else begin
      if (state_r == ST_READ) rd_r <= rd_nxt;
      if (state_r == ST_TIME && tu_done) tv_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pi_r     <= pi_r;
      out_pty_r    <= pty_r;
      out_flags_r  <= {text_ok_r, name_ok_r, ms_r, ta_r, tp_r};
      out_di_r     <= di_r;
      out_rd_r     <= rd_r;
      out_tv_r     <= tv_r;
      out_hour_r   <= ct.hour;
      out_minute_r <= ct.minute;
      out_day_r    <= ct.day;
      out_month_r  <= ct.month;
      out_year_r   <= ct.year;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_program_id   = out_pi_r;
  assign out_program_type = out_pty_r;
  assign out_flags        = out_flags_r;
  assign out_decoder_id   = out_di_r;
  assign out_read_char    = out_rd_r;
  assign out_time_valid   = out_tv_r;
  assign out_hour         = out_hour_r;
  assign out_minute       = out_minute_r;
  assign out_day          = out_day_r;
  assign out_month        = out_month_r;
  assign out_year         = out_year_r;

endmodule

/* bench/rds_group_decoder_core_tb.sv */
// Self-checking bench for rds_group_decoder_core: directed and random RDS groups, reads and
// retunes, with every result checked against a cycle-free predictor of the decoder.
// Depends on rdsgd_pkg and the rds_group_decoder_core RTL only.
`timescale 1ns / 100ps

module rds_group_decoder_core_tb;
  import rdsgd_pkg::*;

  localparam int GROUP_TARGET = 550;   // random stop point, counted in real beats
  localparam int IDLE_LIMIT   = 5000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES = 300;   // longest clock time walk plus margin
  localparam int HOLD_AFTER   = 150;   // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 400;

  // one input beat: operation plus a whole group or a read index
  typedef struct {
    op_t        op;
    logic [15:0] a, b, c, d;
    logic [1:0]  err_a, err_b, err_c, err_d;
    logic [6:0]  read_index;
  } group_beat_t;

  // one result beat
  typedef struct {
    logic [15:0] program_id;
    logic [4:0]  program_type;
    logic [4:0]  flags;
    logic [3:0]  decoder_id;
    logic [7:0]  read_char;
    logic        time_valid;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  day;
    logic [3:0]  month;
    logic [7:0]  year;
  } decoder_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [15:0] in_block_a = '0;
  logic [15:0] in_block_b = '0;
  logic [15:0] in_block_c = '0;
  logic [15:0] in_block_d = '0;
  logic [1:0]  in_error_a = '0;
  logic [1:0]  in_error_b = '0;
  logic [1:0]  in_error_c = '0;
  logic [1:0]  in_error_d = '0;
  logic [6:0]  in_read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_program_id;
  logic [4:0]  out_program_type;
  logic [4:0]  out_flags;
  logic [3:0]  out_decoder_id;
  logic [7:0]  out_read_char;
  logic        out_time_valid;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_day;
  logic [3:0]  out_month;
  logic [7:0]  out_year;

  rds_group_decoder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_block_a       (in_block_a),
    .in_block_b       (in_block_b),
    .in_block_c       (in_block_c),
    .in_block_d       (in_block_d),
    .in_error_a       (in_error_a),
    .in_error_b       (in_error_b),
    .in_error_c       (in_error_c),
    .in_error_d       (in_error_d),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_program_id   (out_program_id),
    .out_program_type (out_program_type),
    .out_flags        (out_flags),
    .out_decoder_id   (out_decoder_id),
    .out_read_char    (out_read_char),
    .out_time_valid   (out_time_valid),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_day          (out_day),
    .out_month        (out_month),
    .out_year         (out_year)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder state as the bench sees it. Stores start at zero, so reading an
  // unwritten slot is legal and returns zero.
  // ---------------------------------------------------------------------------
  logic [7:0]  rt_chars [TEXT_CHARS];
  logic [7:0]  ps_chars [NAME_CHARS];
  logic [3:0]  rt_segs = '0;        // radiotext segments since last wrap
  logic [1:0]  ps_segs = '0;        // station name segments since last wrap
  logic        rt_ok = 1'b0;
  logic        ps_ok = 1'b0;
  logic [15:0] pi_code = '0;
  logic [4:0]  pty_code = '0;
  logic        tp_bit = 1'b0, ta_bit = 1'b0, ms_bit = 1'b0;
  logic [3:0]  di_bits = '0;
  clock_time_t local_time = '0;
  int          month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  group_beat_t  group_queue [$];     // beats still to be offered
  decoder_out_t decoded_groups [$];  // predicted results, oldest first
  int           mismatch_count = 0;
  int           beats_queued = 0;    // real beats only, OP_NONE not counted

  initial begin
    foreach (rt_chars[i]) rt_chars[i] = '0;
    foreach (ps_chars[i]) ps_chars[i] = '0;
  end

  // Advances the bench's copy of the decoder by one accepted beat and returns
  // the result that beat must produce.
  function automatic decoder_out_t decode_group(group_beat_t g);
    decoder_out_t r;
    int          mjd, hr, mn, off, days_left, mins, mon;
    logic [7:0]  dd, yy;
    logic [5:0]  rt_base;
    logic [1:0]  seg;
    bit          clean;
    r = '{default: '0};
    clean = (g.err_a != ERR_UNCORR) && (g.err_b != ERR_UNCORR) &&
            (g.err_c != ERR_UNCORR) && (g.err_d != ERR_UNCORR);
    case (g.op)
      OP_DECODE: begin
        if (clean) begin
          // version bit B11 plays no part in the type match
          if (g.b[15:12] == GT_TEXT) begin
            rt_base = {g.b[3:0], 2'b00};
            rt_chars[rt_base]     = g.c[15:8];
            rt_chars[rt_base + 1] = g.c[7:0];
            rt_chars[rt_base + 2] = g.d[15:8];
            rt_chars[rt_base + 3] = g.d[7:0];
            rt_segs = rt_segs + 4'd1;
            if (rt_segs == 4'd0) rt_ok = 1'b1;
          end else if (g.b[15:12] == GT_CLOCK) begin
            mjd = int'({g.b[1:0], g.c[15:1]});
            hr  = int'({g.c[0], g.d[15:12]});
            mn  = int'(g.d[11:6]);
            off = int'(g.d[4:0]);
            if (g.d[5]) off = -off;
            // month walk from January 2010, no leap years
            dd = 8'd1;
            mon = 0;
            yy = 8'(START_YEAR);
            days_left = mjd - MJD_2010 + 1;
            while (days_left > 0) begin
              dd = days_left[7:0];
              mon++;
              if (mon == 13) begin
                mon = 1;
                yy = yy + 8'd1;
              end
              days_left -= month_len[mon - 1];
            end
            // one day correction only, so day may land on 0 or 32
            mins = mn + HOUR_MINUTES * hr + HALF_HOUR * off;
            if (mins >= DAY_MINUTES) begin
              mins -= DAY_MINUTES;
              dd = dd + 8'd1;
            end
            if (mins < 0) begin
              mins += DAY_MINUTES;
              dd = dd - 8'd1;
            end
            local_time.hour   = 5'(mins / HOUR_MINUTES);
            local_time.minute = 6'(mins % HOUR_MINUTES);
            local_time.day    = dd[5:0];
            local_time.month  = 4'(mon);
            local_time.year   = yy;
            r.time_valid = 1'b1;
          end else if (g.b[15:12] == GT_BASIC) begin
            seg = g.b[1:0];
            di_bits[seg] = g.b[2];
            ms_bit = g.b[3];
            ta_bit = g.b[4];
            ps_chars[{seg, 1'b0}] = g.d[15:8];
            ps_chars[{seg, 1'b1}] = g.d[7:0];
            ps_segs = ps_segs + 2'd1;
            if (ps_segs == 2'd0) ps_ok = 1'b1;
          end
        end
        // PI, PTY and TP follow every decode, clean or not
        pi_code  = g.a;
        pty_code = g.b[9:5];
        tp_bit   = g.b[10];
      end
      OP_READ: begin
        if (g.read_index < TEXT_CHARS)
          r.read_char = rt_chars[g.read_index[5:0]];
        else if (g.read_index < TEXT_CHARS + NAME_CHARS)
          r.read_char = ps_chars[g.read_index[2:0]];
      end
      OP_RETUNE: begin
        rt_segs = '0;
        ps_segs = '0;
        rt_ok = 1'b0;
        ps_ok = 1'b0;
      end
      default: ;
    endcase
    r.program_id   = pi_code;
    r.program_type = pty_code;
    r.flags        = {rt_ok, ps_ok, ms_bit, ta_bit, tp_bit};
    r.decoder_id   = di_bits;
    r.hour         = local_time.hour;
    r.minute       = local_time.minute;
    r.day          = local_time.day;
    r.month        = local_time.month;
    r.year         = local_time.year;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------
  function automatic group_beat_t noise_beat();
    group_beat_t g;
    g.op = op_t'($urandom_range(0, 2));
    g.a = 16'($urandom);
    g.b = 16'($urandom);
    g.c = 16'($urandom);
    g.d = 16'($urandom);
    g.err_a = 2'($urandom_range(0, 3));
    g.err_b = 2'($urandom_range(0, 3));
    g.err_c = 2'($urandom_range(0, 3));
    g.err_d = 2'($urandom_range(0, 3));
    g.read_index = 7'($urandom);
    return g;
  endfunction

  // error-free decode of the given group type, rest random
  function automatic group_beat_t clean_group(logic [3:0] gtype);
    group_beat_t g;
    g = noise_beat();
    g.op = OP_DECODE;
    g.err_a = 2'($urandom_range(0, 2));
    g.err_b = 2'($urandom_range(0, 2));
    g.err_c = 2'($urandom_range(0, 2));
    g.err_d = 2'($urandom_range(0, 2));
    g.b[15:12] = gtype;
    return g;
  endfunction

  // offset is in half hours, neg gives the sign bit
  function automatic group_beat_t clock_group(logic [16:0] mjd, logic [4:0] hr,
                                              logic [5:0] mn, logic neg, logic [4:0] off);
    group_beat_t g;
    g = clean_group(GT_CLOCK);
    g.b[1:0] = mjd[16:15];
    g.c = {mjd[14:0], hr[4]};
    g.d = {hr[3:0], mn, neg, off};
    return g;
  endfunction

  function automatic group_beat_t read_beat(logic [6:0] idx);
    group_beat_t g;
    g = noise_beat();
    g.op = OP_READ;
    g.read_index = idx;
    return g;
  endfunction

  task automatic queue_beat(group_beat_t g);
    group_queue.push_back(g);
    if (g.op != OP_NONE) beats_queued++;
  endtask

  // one garbled block now and then when broken is set
  task automatic spoil(inout group_beat_t g, input bit broken);
    if (broken && $urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0: g.err_a = ERR_UNCORR;
        1: g.err_b = ERR_UNCORR;
        2: g.err_c = ERR_UNCORR;
        default: g.err_d = ERR_UNCORR;
      endcase
    end
  endtask

  // all sixteen radiotext segments in shuffled order, n of them
  task automatic queue_text_run(int n, bit broken);
    int order [16];
    int j, tmp;
    group_beat_t g;
    foreach (order[i]) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      g = clean_group(GT_TEXT);
      g.b[3:0] = 4'(order[i]);
      spoil(g, broken);
      queue_beat(g);
      if ($urandom_range(0, 7) == 0) queue_beat(read_beat(7'($urandom_range(0, 71))));
    end
  endtask

  task automatic queue_name_run(bit broken);
    int order [4];
    int j, tmp;
    group_beat_t g;
    foreach (order[i]) order[i] = i;
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 4; i++) begin
      g = clean_group(GT_BASIC);
      g.b[1:0] = 2'(order[i]);
      spoil(g, broken);
      queue_beat(g);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    group_beat_t g;
    int pick;
    logic [16:0] mjd;

    // directed: all-zero type 0 group, then an all-ones group of an unused type
    g = clean_group(GT_BASIC);
    g.a = '0; g.b = '0; g.c = '0; g.d = '0;
    g.err_a = '0; g.err_b = '0; g.err_c = '0; g.err_d = '0;
    queue_beat(g);
    g.a = '1; g.b = '1; g.c = '1; g.d = '1;
    g.err_a = 2'd2; g.err_b = 2'd2; g.err_c = 2'd2; g.err_d = 2'd2;
    queue_beat(g);
    // radiotext, last segment, version B bit set
    g = clean_group(GT_TEXT);
    g.b[11] = 1'b1;
    g.b[3:0] = 4'hF;
    g.c = 16'h4142;
    g.d = 16'h4344;
    queue_beat(g);
    // radiotext with block A uncorrectable: nothing stored
    g = clean_group(GT_TEXT);
    g.b[3:0] = 4'h0;
    g.err_a = ERR_UNCORR;
    queue_beat(g);
    // station name segment 3 with TA, MS and DI set
    g = clean_group(GT_BASIC);
    g.b[4:0] = 5'b11111;
    g.d = 16'h5AA5;
    queue_beat(g);
    // station name dropped for each of blocks B, C, D uncorrectable
    g = clean_group(GT_BASIC);
    g.err_b = ERR_UNCORR;
    queue_beat(g);
    g = clean_group(GT_BASIC);
    g.err_c = ERR_UNCORR;
    queue_beat(g);
    g = clean_group(GT_BASIC);
    g.err_d = ERR_UNCORR;
    queue_beat(g);
    // clock time with block D uncorrectable: time unchanged, time_valid low
    g = clock_group(17'd60000, 5'd10, 6'd30, 1'b0, 5'd2);
    g.err_d = ERR_UNCORR;
    queue_beat(g);
    // reads across both stores and past their end
    queue_beat(read_beat(7'd60));
    queue_beat(read_beat(7'd63));
    queue_beat(read_beat(7'd0));
    queue_beat(read_beat(7'd64));
    queue_beat(read_beat(7'd70));
    queue_beat(read_beat(7'd71));
    queue_beat(read_beat(7'd72));
    queue_beat(read_beat(7'd127));
    // unused operation
    g = noise_beat();
    g.op = OP_NONE;
    queue_beat(g);
    // dates well before 2010 and on its last day before
    queue_beat(clock_group(17'd50000, 5'd8, 6'd15, 1'b0, 5'd0));
    queue_beat(clock_group(17'd55197, 5'd12, 6'd0, 1'b1, 5'd4));
    // offset pulls 2010-01-01 00:00 back to day 0
    queue_beat(clock_group(17'd55198, 5'd0, 6'd0, 1'b1, 5'd2));
    // offset pushes Jan 31 23:59 onto day 32
    queue_beat(clock_group(17'd55228, 5'd23, 6'd59, 1'b0, 5'd2));
    // hour and minute above their ranges, largest offsets, largest date
    queue_beat(clock_group(17'd58000, 5'd31, 6'd63, 1'b0, 5'd31));
    queue_beat(clock_group(17'h1FFFF, 5'd0, 6'd0, 1'b1, 5'd31));
    g = noise_beat();
    g.op = OP_RETUNE;
    queue_beat(g);
    queue_beat(read_beat(7'd71));

    // random: mostly complete text and name cycles, with noise in between
    while (beats_queued < GROUP_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        queue_text_run(16, $urandom_range(0, 3) == 0);
      end else if (pick < 40) begin
        queue_name_run($urandom_range(0, 3) == 0);
      end else if (pick < 55) begin
        // mostly dates after 2010; sometimes anything the 17 bits allow
        if ($urandom_range(0, 7) == 0) mjd = 17'($urandom_range(0, 131071));
        else mjd = 17'($urandom_range(55000, 66000));
        queue_beat(clock_group(mjd,
          ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23)),
          ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59)),
          1'($urandom_range(0, 1)), 5'($urandom_range(0, 31))));
      end else if (pick < 68) begin
        if ($urandom_range(0, 4) == 0) queue_beat(read_beat(7'($urandom_range(0, 127))));
        else queue_beat(read_beat(7'($urandom_range(0, 71))));
      end else if (pick < 72) begin
        g = noise_beat();
        g.op = OP_RETUNE;
        queue_beat(g);
      end else if (pick < 86) begin
        g = noise_beat();
        g.op = OP_DECODE;
        queue_beat(g);
      end else if (pick < 90) begin
        g = noise_beat();
        g.op = OP_NONE;
        queue_beat(g);
      end else begin
        // text cycle cut short by a retune
        queue_text_run($urandom_range(1, 8), 1'b0);
        g = noise_beat();
        g.op = OP_RETUNE;
        queue_beat(g);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (group_queue.size() != 0 || in_valid || decoded_groups.size() != 0)
      @(posedge clk);
    // anything arriving now is an extra beat and gets flagged by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. The predictor
  // runs at the edge where a beat is taken.
  // ---------------------------------------------------------------------------
  group_beat_t offered_group;
  int          burst_left = 0;
  int          gap_left = 0;

  always @(posedge clk) begin : group_driver
    group_beat_t g;
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) decoded_groups.push_back(decode_group(offered_group));
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (group_queue.size() != 0) begin
        g = group_queue.pop_front();
        offered_group = g;
        in_operation  <= g.op;
        in_block_a    <= g.a;
        in_block_b    <= g.b;
        in_block_c    <= g.c;
        in_block_d    <= g.d;
        in_error_a    <= g.err_a;
        in_error_b    <= g.err_b;
        in_error_c    <= g.err_c;
        in_error_d    <= g.err_d;
        in_read_index <= g.read_index;
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // next burst; a zero gap often joins bursts into long runs
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            9:          gap_left = $urandom_range(20, 60);
            default:    gap_left = $urandom_range(1, 8);
          endcase
        end
      end
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches between modes; once, a long hold-off
  // lets the decoder fill up and push back on the sender.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;
  int results_taken = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : result_receiver
    logic next_stall;
    next_stall = 1'b0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) results_taken++;
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        stall_phase++;
        case (stall_mode)
          0: next_stall = 1'b0;                          // free flow
          1: next_stall = ($urandom_range(0, 3) == 0);   // light
          2: next_stall = 1'($urandom_range(0, 1));      // heavy
          default: next_stall = ((stall_phase % 5) < 3); // periodic
        endcase
      end
      out_stall <= next_stall;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    decoder_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_groups.size() == 0) begin
        $error("result beat with no prediction waiting");
        mismatch_count++;
      end else begin
        want = decoded_groups.pop_front();
        check_field("program_id", want.program_id, out_program_id);
        check_field("program_type", 16'(want.program_type), 16'(out_program_type));
        check_field("flags", 16'(want.flags), 16'(out_flags));
        check_field("decoder_id", 16'(want.decoder_id), 16'(out_decoder_id));
        check_field("read_char", 16'(want.read_char), 16'(out_read_char));
        check_field("time_valid", 16'(want.time_valid), 16'(out_time_valid));
        check_field("hour", 16'(want.hour), 16'(out_hour));
        check_field("minute", 16'(want.minute), 16'(out_minute));
        check_field("day", 16'(want.day), 16'(out_day));
        check_field("month", 16'(want.month), 16'(out_month));
        check_field("year", 16'(want.year), 16'(out_year));
      end
    end
  end

  // Watchdog: a long clock walk plus the hold-off stays far below the limit.
  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

/* rds_group_decoder_core.f */
hdl/rdsgd_pkg.sv
hdl/rdsgd_time_unit.sv
hdl/rds_group_decoder_core.sv
bench/rds_group_decoder_core_tb.sv
